### rtl/core/assert_macros.svh
// assertion macros shared by the checker modules
// needs signals named clock and reset in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sai_pkg.sv
// shared constants, codes and the cell command struct of the shifting array
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sai_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int MODE_W   = 3;
   localparam int POS_W    = 6;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 7;

   typedef enum logic [MODE_W-1:0] {
      MODE_INS_AT   = 3'd0,
      MODE_INS_END  = 3'd1,
      MODE_DEL_AT   = 3'd2,
      MODE_DEL_END  = 3'd3,
      MODE_MODIFY   = 3'd4,
      MODE_TRAVERSE = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BADIDX = 2'd2,
      STATUS_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD = 3'd0,
      CELL_INS  = 3'd1,
      CELL_DEL  = 3'd2,
      CELL_MOD  = 3'd3,
      CELL_ROT  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [FILL_W-1:0]  pos;
      logic [IDX_W-1:0]   tail;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

endpackage

`default_nettype wire

### rtl/core/sai_cell.sv
// one entry of the shifting array, takes from its neighbors on command
// depends on sai_pkg
`timescale 1ns / 1ps
`default_nettype none

module sai_cell (
   input  wire logic                        clock,
   input  wire sai_pkg::cell_cmd_type       cmd,
   input  wire logic [sai_pkg::IDX_W-1:0]   index,
   input  wire logic [sai_pkg::DATA_W-1:0]  data_left,
   input  wire logic [sai_pkg::DATA_W-1:0]  data_right,
   input  wire logic [sai_pkg::DATA_W-1:0]  head,
   output logic      [sai_pkg::DATA_W-1:0]  data
);
   import sai_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic [FILL_W-1:0] idx_x;

   assign idx_x = FILL_W'(index);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_INS: begin
            if (idx_x == cmd.pos) begin
               data_in = cmd.value;
            end else if (idx_x > cmd.pos) begin
               data_in = data_left;
            end
         end
         CELL_DEL: begin
            if (idx_x >= cmd.pos) begin
               data_in = data_right;
            end
         end
         CELL_MOD: begin
            if (idx_x == cmd.pos) begin
               data_in = cmd.value;
            end
         end
         CELL_ROT: begin
            if (index == cmd.tail) begin
               data_in = head;
            end else begin
               data_in = data_right;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

### rtl/core/sai_ctrl.sv
// request decode, fill count, traverse sequencing and result register
// depends on sai_pkg
`timescale 1ns / 1ps
`default_nettype none

module sai_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [sai_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [sai_pkg::POS_W-1:0]     req_position,
   input  wire logic [sai_pkg::DATA_W-1:0]    req_value_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic      [sai_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [sai_pkg::DATA_W-1:0]    rsp_value_out,
   output logic      [sai_pkg::FILL_W-1:0]    rsp_fill_count,
   output logic                               rsp_last,
   input  wire logic [sai_pkg::DATA_W-1:0]    head,
   output sai_pkg::cell_cmd_type              cmd
);
   import sai_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_TRAV
   } state_type;

   state_type             state_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [DATA_W-1:0]     rsp_value_ff;
   logic [FILL_W-1:0]     rsp_fill_ff;
   logic                  rsp_last_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [IDX_W-1:0]      idx_ff;

   logic                  take_out;
   logic                  accept;
   logic                  rsp_load;
   logic                  trav_go;
   logic                  trav_last;
   status_type            dec_status;
   cell_op_type           dec_op;
   logic [FILL_W-1:0]     dec_pos;
   logic [FILL_W-1:0]     pos_x;
   logic [FILL_W-1:0]     cnt_x;
   logic [IDX_W-1:0]      tail;

   assign take_out  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && take_out;
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (accept && !trav_go) || ((state_ff == ST_TRAV) && take_out);
   assign pos_x     = FILL_W'(req_position);
   assign cnt_x     = FILL_W'(count_ff);
   assign tail      = IDX_W'(count_ff - CNT_W'(1));
   assign trav_last = (idx_ff == tail);

   always_comb begin
      dec_status = STATUS_OK;
      dec_op     = CELL_HOLD;
      dec_pos    = pos_x;
      count_in   = count_ff;
      trav_go    = 1'b0;
      case (mode_type'(req_mode))
         MODE_INS_AT: begin
            if (cnt_x >= FILL_W'(DEPTH)) begin
               dec_status = STATUS_FULL;
            end else if (pos_x > cnt_x) begin
               dec_status = STATUS_BADIDX;
            end else begin
               dec_op   = CELL_INS;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_INS_END: begin
            if (cnt_x >= FILL_W'(DEPTH)) begin
               dec_status = STATUS_FULL;
            end else begin
               dec_op   = CELL_INS;
               dec_pos  = cnt_x;
               count_in = count_ff + CNT_W'(1);
            end
         end
         MODE_DEL_AT: begin
            if (pos_x >= cnt_x) begin
               dec_status = STATUS_BADIDX;
            end else begin
               dec_op   = CELL_DEL;
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_DEL_END: begin
            if (count_ff == '0) begin
               dec_status = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
            end
         end
         MODE_MODIFY: begin
            if (pos_x >= cnt_x) begin
               dec_status = STATUS_BADIDX;
            end else begin
               dec_op = CELL_MOD;
            end
         end
         MODE_TRAVERSE: begin
            if (count_ff == '0) begin
               dec_status = STATUS_EMPTY;
            end else begin
               trav_go = 1'b1;
            end
         end
         default: dec_status = STATUS_BADIDX;
      endcase
   end

   always_comb begin
      cmd.op    = CELL_HOLD;
      cmd.pos   = dec_pos;
      cmd.tail  = tail;
      cmd.value = req_value_in;
      if (accept) begin
         cmd.op = dec_op;
      end else if ((state_ff == ST_TRAV) && take_out) begin
         cmd.op = CELL_ROT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  count_ff <= count_in;
                  if (trav_go) begin
                     state_ff <= ST_TRAV;
                     idx_ff   <= '0;
                  end else begin
                     rsp_status_ff <= dec_status;
                     rsp_value_ff  <= '0;
                     rsp_fill_ff   <= FILL_W'(count_in);
                     rsp_last_ff   <= 1'b1;
                  end
               end
            end
            ST_TRAV: begin
               if (take_out) begin
                  rsp_status_ff <= STATUS_OK;
                  rsp_value_ff  <= head;
                  rsp_fill_ff   <= cnt_x;
                  rsp_last_ff   <= trav_last;
                  idx_ff        <= idx_ff + IDX_W'(1);
                  if (trav_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_value_out  = rsp_value_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

### rtl/core/shift_array_insert_delete_top.sv
// for insert, delete, modify and errors the result is valid in the cycle after acceptance
// one item per cycle for those while results are taken; a traverse blocks new requests
// while the cell chain rotates one entry into the result register each cycle it is taken
// reset: synchronous, active high; clears the fill count and control, entries stay undefined
// top level: control unit and the chain of entry cells; depends on sai_pkg, sai_ctrl, sai_cell
`timescale 1ns / 1ps
`default_nettype none

module shift_array_insert_delete_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic        [sai_pkg::MODE_W-1:0]   req_mode,
   input  wire logic        [sai_pkg::POS_W-1:0]    req_position,
   input  wire logic signed [sai_pkg::DATA_W-1:0]   req_value_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic             [sai_pkg::STATUS_W-1:0] rsp_status,
   output logic signed      [sai_pkg::DATA_W-1:0]   rsp_value_out,
   output logic             [sai_pkg::FILL_W-1:0]   rsp_fill_count,
   output logic                                     rsp_last
);
   import sai_pkg::*;

   cell_cmd_type       cmd;
   logic [DATA_W-1:0]  cell_data [DEPTH];
   logic [DATA_W-1:0]  value_out;

   sai_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value_in   (req_value_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_value_out  (value_out),
      .rsp_fill_count (rsp_fill_count),
      .rsp_last       (rsp_last),
      .head           (cell_data[0]),
      .cmd            (cmd)
   );

   assign rsp_value_out = value_out;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (g == 0) begin : g_first
         assign left_data = cell_data[g];
      end else begin : g_inner_left
         assign left_data = cell_data[g-1];
      end

      if (g == DEPTH - 1) begin : g_final
         assign right_data = cell_data[g];
      end else begin : g_inner_right
         assign right_data = cell_data[g+1];
      end

      sai_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .index      (IDX_W'(g)),
         .data_left  (left_data),
         .data_right (right_data),
         .head       (cell_data[0]),
         .data       (cell_data[g])
      );
   end

endmodule

`default_nettype wire

### rtl/core/sai_checker.sv
// port level checks of the shifting array, bound to the top level
// depends on sai_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sai_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_ready,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   input  wire logic [sai_pkg::STATUS_W-1:0]  rsp_status,
   input  wire logic [sai_pkg::DATA_W-1:0]    rsp_value_out,
   input  wire logic [sai_pkg::FILL_W-1:0]    rsp_fill_count,
   input  wire logic                          rsp_last
);
   import sai_pkg::*;

   logic rsp_stall;
   logic rsp_error;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_error = (rsp_status != STATUS_OK);

   `ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_value_out) && $stable(rsp_status), "item changed while stalled")
   `ASSERT_IMPLIES(a_no_accept_on_stall, rsp_stall, !req_ready, "request taken while item stalled")
   `ASSERT_IMPLIES(a_fill_bound, rsp_valid, rsp_fill_count <= FILL_W'(DEPTH), "fill count above depth")
   `ASSERT_IMPLIES(a_full_at_depth, rsp_valid && (rsp_status == STATUS_FULL), rsp_fill_count == FILL_W'(DEPTH), "full status below depth")
   `ASSERT_IMPLIES(a_error_last, rsp_valid && rsp_error, rsp_last && (rsp_value_out == '0), "error item not single")

endmodule

bind shift_array_insert_delete_top sai_checker u_sai_checker (.*);

`default_nettype wire
